// ===== hdl/crc32c_length_padded_hash_assert.svh =====
// assertion macros for the length-padded crc32c hash
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CRC32C_LENGTH_PADDED_HASH_ASSERT_SVH
`define CRC32C_LENGTH_PADDED_HASH_ASSERT_SVH

// checked only outside reset
`define CLPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CLPH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/clph_pkg.sv =====
// types, microcode table and byte-wise crc32c update for the length-padded hash
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package clph_pkg;

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LEN0 = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PAD  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT = 4'd10;

    // byte fed into the crc in a step
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_DATA,
        SRC_LEN,
        SRC_PAD
    } t_src;

    // jump condition: taken goes to target, otherwise the step repeats
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_FINISH,
        COND_PHASE0,
        COND_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic              accept;
        logic              emit;
        t_src              src;
        logic [2:0]        len_idx;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w.accept  = 1'b0;
        w.emit    = 1'b0;
        w.src     = SRC_NONE;
        w.len_idx = 3'd0;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_IDLE;
        case (step)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.src    = SRC_DATA;
                w.cond   = COND_FINISH;
                w.target = STEP_LEN0;
            end
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
                w.src     = SRC_LEN;
                w.len_idx = 3'(step - STEP_LEN0);
                w.target  = step + 4'd1;
            end
            STEP_PAD: begin
                w.src    = SRC_PAD;
                w.cond   = COND_PHASE0;
                w.target = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
            end
            default: begin
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // reflected crc update by one byte, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/crc32c_length_padded_hash.sv =====
// length-padded crc32c stream hash, microcoded sequencer over one crc datapath
// depends on clph_pkg and crc32c_length_padded_hash_assert.svh
//
// channel  | valid   | ready   | payload
// ---------+---------+---------+---------------------
// input    | i_valid | o_ready | i_kind, i_data_byte
// result   | o_valid | i_ready | o_hash_value
//
// a data byte is absorbed while the sequencer stays on its idle step
// a finish runs through the accept, eight length steps, one pad step per pad byte
// plus one that sees the aligned count, then one emit step
// the emit step waits while the previous result has not been taken
// the result register holds the hash until its transfer, the next item may enter meanwhile
// synchronous active-low reset clears the step counter, crc, counter and result valid
`timescale 1ns / 1ps
`default_nettype none

module crc32c_length_padded_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_hash_value
);

    logic [clph_pkg::STEP_W-1:0] r_step, n_step;
    logic [31:0]                 r_crc, n_crc;
    logic [63:0]                 r_count, n_count;
    logic [2:0]                  r_pad, n_pad;
    logic                        r_o_valid, n_o_valid;
    logic [31:0]                 r_hash, n_hash;

    clph_pkg::t_ctrl ctrl;
    logic            in_xfer;
    logic            cond_met;
    logic            absorb;
    logic [7:0]      len_byte;
    logic [7:0]      src_byte;

    assign ctrl     = clph_pkg::ucode(r_step);
    assign o_ready  = ctrl.accept;
    assign in_xfer  = i_valid && ctrl.accept;
    // length byte k is taken from the running count, which keeps counting
    assign len_byte = 8'(r_count >> {ctrl.len_idx, 3'b000});

    always_comb begin
        case (ctrl.cond)
            clph_pkg::COND_ALWAYS:   cond_met = 1'b1;
            clph_pkg::COND_FINISH:   cond_met = in_xfer && i_kind;
            clph_pkg::COND_PHASE0:   cond_met = (r_count[2:0] == 3'd0);
            clph_pkg::COND_OUT_FREE: cond_met = !r_o_valid || i_ready;
            default:                 cond_met = 1'b1;
        endcase

        case (ctrl.src)
            clph_pkg::SRC_DATA: begin
                absorb   = in_xfer && !i_kind;
                src_byte = i_data_byte;
            end
            clph_pkg::SRC_LEN: begin
                absorb   = 1'b1;
                src_byte = len_byte;
            end
            clph_pkg::SRC_PAD: begin
                absorb   = !cond_met;
                src_byte = {5'd0, r_pad};
            end
            default: begin
                absorb   = 1'b0;
                src_byte = 8'd0;
            end
        endcase

        n_step    = cond_met ? ctrl.target : r_step;
        n_crc     = r_crc;
        n_count   = r_count;
        n_pad     = r_pad;
        n_hash    = r_hash;
        n_o_valid = r_o_valid && !i_ready;

        if (absorb) begin
            n_crc   = clph_pkg::crc_byte(r_crc, src_byte);
            n_count = r_count + 64'd1;
            if (ctrl.src == clph_pkg::SRC_PAD) begin
                n_pad = r_pad + 3'd1;
            end
        end

        if (ctrl.emit && cond_met) begin
            n_hash    = r_crc;
            n_o_valid = 1'b1;
            n_crc     = 32'd0;
            n_count   = 64'd0;
            n_pad     = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= clph_pkg::STEP_IDLE;
            r_crc     <= 32'd0;
            r_count   <= 64'd0;
            r_pad     <= 3'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_crc     <= n_crc;
            r_count   <= n_count;
            r_pad     <= n_pad;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_valid      = r_o_valid;
    assign o_hash_value = r_hash;

`include "crc32c_length_padded_hash_assert.svh"

    `CLPH_ASSERT(a_finish_starts_len, (in_xfer && i_kind) |=> (r_step == clph_pkg::STEP_LEN0), "finish did not start length steps")
    `CLPH_ASSERT(a_emit_aligned, (r_step == clph_pkg::STEP_EMIT) |-> (r_count[2:0] == 3'd0), "emit with unaligned byte count")
    `CLPH_ASSERT(a_valid_from_emit, $rose(o_valid) |-> ($past(r_step) == clph_pkg::STEP_EMIT), "result without emit step")
    `CLPH_ASSERT(a_emit_clears, (ctrl.emit && cond_met) |=> (r_count == 64'd0 && r_crc == 32'd0 && r_step == clph_pkg::STEP_IDLE), "state not cleared after emit")
    `CLPH_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!o_valid && r_step == clph_pkg::STEP_IDLE), "reset left block busy")

endmodule

`default_nettype wire

// ===== bench/tb_crc32c_length_padded_hash.sv =====
// self-checking bench for the length-padded crc32c stream hash
// depends on crc32c_length_padded_hash; the expected hash comes from a bit-serial model
`timescale 1ns / 1ps

module tb_crc32c_length_padded_hash;

    localparam logic        ITEM_DATA   = 1'b0;
    localparam logic        ITEM_FINISH = 1'b1;
    localparam logic [31:0] CASTAGNOLI  = 32'h82F6_3B78;
    localparam int          IDLE_PCT    = 34;
    localparam int          CALM_FROM   = 200;
    localparam int          CALM_TO     = 330;
    localparam int          TAIL_CYCLES = 40;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_kind = ITEM_DATA;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_hash_value;

    t_item       pending_items[$];
    logic [31:0] expected_hashes[$];

    // running model state
    logic [31:0] model_crc = 32'd0;
    logic [63:0] model_len = 64'd0;
    logic [2:0]  model_phase = 3'd0;

    int errors = 0;
    int n_taken = 0;
    int n_hashes = 0;
    int n_bytes = 0;
    int longest = 0;

    crc32c_length_padded_hash u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] shift_in_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ CASTAGNOLI;
            else      c = c >> 1;
        end
        return c;
    endfunction

    task automatic model_absorb(input logic [7:0] b);
        model_crc   = shift_in_byte(model_crc, b);
        model_len   = model_len + 64'd1;
        model_phase = model_phase + 3'd1;
    endtask

    // length bytes read the counter as it keeps counting, then pad 0,1,2,...
    task automatic model_take(input t_item it);
        logic [7:0] pad;
        if (it.kind == ITEM_DATA) begin
            model_absorb(it.data);
        end else begin
            for (int k = 0; k < 8; k++) begin
                model_absorb(8'(model_len >> (8 * k)));
            end
            pad = 8'd0;
            while (model_phase != 3'd0) begin
                model_absorb(pad);
                pad = pad + 8'd1;
            end
            expected_hashes.push_back(model_crc);
            model_crc   = 32'd0;
            model_len   = 64'd0;
            model_phase = 3'd0;
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_item it;
        it.kind = ITEM_DATA;
        it.data = b;
        pending_items.push_back(it);
    endtask

    task automatic queue_finish(input logic [7:0] junk);
        t_item it;
        it.kind = ITEM_FINISH;
        it.data = junk;
        pending_items.push_back(it);
    endtask

    function automatic logic calm();
        return (n_taken >= CALM_FROM) && (n_taken < CALM_TO);
    endfunction

    // driver: offers the next pending item, holds it until its transfer
    always @(posedge i_clk) begin
        t_item it;
        logic  fire;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            fire = i_valid && o_ready;
            if (fire) begin
                it.kind = i_kind;
                it.data = i_data_byte;
                model_take(it);
                n_taken = n_taken + 1;
            end
            if (!i_valid || fire) begin
                if (pending_items.size() > 0 &&
                    (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    it = pending_items.pop_front();
                    i_valid     <= 1'b1;
                    i_kind      <= it.kind;
                    i_data_byte <= it.data;
                end else begin
                    i_valid     <= 1'b0;
                    i_kind      <= 1'($urandom_range(0, 1));
                    i_data_byte <= 8'($urandom_range(0, 255));
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest expected hash
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_hashes.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected hash, expected none, actual %08h",
                             $time, o_hash_value);
                end else begin
                    want = expected_hashes.pop_front();
                    n_hashes = n_hashes + 1;
                    if (o_hash_value !== want) begin
                        errors = errors + 1;
                        $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                                 $time, want, o_hash_value);
                    end
                end
            end
            i_ready <= calm() || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        int len;
        int sel;
        int items;

        // empty messages, with the ignored byte at both extremes
        queue_finish(8'hFF);
        queue_finish(8'h00);
        // one byte, seven pad bytes needed
        queue_byte(8'hFF);
        queue_finish(8'h5A);
        // eight bytes, no padding
        queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'h80); queue_byte(8'h01);
        queue_byte(8'h55); queue_byte(8'hAA); queue_byte(8'h7F); queue_byte(8'hFE);
        queue_finish(8'hA5);
        // seven bytes, one pad byte
        for (int i = 0; i < 7; i++) queue_byte(8'(8'h11 * i));
        queue_finish(8'h00);

        // one long message so the second length byte is non-zero
        len = $urandom_range(260, 300);
        for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
        queue_finish(8'($urandom_range(0, 255)));
        if (len > longest) longest = len;

        items = pending_items.size();
        while (items < 500) begin
            sel = $urandom_range(0, 99);
            if (sel < 85)      len = $urandom_range(0, 20);
            else if (sel < 97) len = $urandom_range(21, 70);
            else               len = $urandom_range(120, 200);
            for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(0, 255)));
            queue_finish(8'($urandom_range(0, 255)));
            if (len > longest) longest = len;
            items = pending_items.size();
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_hashes.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_hashes.size() > 0) begin
            errors = errors + 1;
            $display("%0t: %0d hashes never arrived", $time, expected_hashes.size());
        end
        $display("covered %0d items, %0d hashes checked, longest message %0d bytes",
                 n_taken, n_hashes, longest);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
